// File: hw/rtl/utf8_stream_decoder_defines.svh
// Assertion macros for the UTF-8 stream decoder.
// Included by the top level; needs no other file.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define UFD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("UFD assertion failed: implication");
// Next-cycle implication, disabled while reset is high.
`define UFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("UFD assertion failed: next-cycle implication");
`else
`define UFD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define UFD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/ufd_pkg.sv
// Shared types, constants and byte classification functions for the
// UTF-8 stream decoder. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ufd_pkg;

   localparam int ByteW = 8;
   localparam int CodeW = 21;
   localparam int MaxResults = 4;
   localparam int PendDepth = 3;

   localparam logic [CodeW-1:0] InvalidCodeReset = 21'd65533;

   // Lead byte boundaries and the continuation byte pattern.
   localparam logic [ByteW-1:0] AsciiLimit = 8'h80;
   localparam logic [ByteW-1:0] Lead2Low = 8'hC0;
   localparam logic [ByteW-1:0] Lead2High = 8'hDF;
   localparam logic [ByteW-1:0] Lead3High = 8'hEF;
   localparam logic [ByteW-1:0] ContMask = 8'hC0;
   localparam logic [ByteW-1:0] ContPattern = 8'h80;

   // Sequence lengths; LenNone marks a stray continuation byte.
   localparam logic [2:0] LenNone = 3'd0;
   localparam logic [2:0] Len1 = 3'd1;
   localparam logic [2:0] Len2 = 3'd2;
   localparam logic [2:0] Len3 = 3'd3;
   localparam logic [2:0] Len4 = 3'd4;

   typedef struct packed {
      logic [CodeW-1:0] code_point;
      logic malformed;
      logic last_of_run;
   } result_type;

   typedef struct packed {
      result_type [MaxResults-1:0] entry;
      logic [2:0] count;
   } batch_type;

   function automatic logic [2:0] seq_len(input logic [ByteW-1:0] lead);
      logic [2:0] len;
      if (lead < AsciiLimit) begin
         len = Len1;
      end else if (lead < Lead2Low) begin
         len = LenNone;
      end else if (lead <= Lead2High) begin
         len = Len2;
      end else if (lead <= Lead3High) begin
         len = Len3;
      end else begin
         len = Len4;
      end
      return len;
   endfunction

   function automatic logic is_cont(input logic [ByteW-1:0] b);
      return (b & ContMask) == ContPattern;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ufd_channels_if.sv
// Valid/ready channel interfaces for the UTF-8 stream decoder: byte input,
// code point output and the configuration write port. Depends on ufd_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface ufd_req_if;
   logic valid;
   logic ready;
   logic [ufd_pkg::ByteW-1:0] data_byte;
   logic end_of_string;
   modport source(output valid, output data_byte, output end_of_string, input ready);
   modport sink(input valid, input data_byte, input end_of_string, output ready);
endinterface

interface ufd_rsp_if;
   logic valid;
   logic ready;
   logic [ufd_pkg::CodeW-1:0] code_point;
   logic malformed;
   logic last_of_run;
   modport source(output valid, output code_point, output malformed,
                  output last_of_run, input ready);
   modport sink(input valid, input code_point, input malformed,
                input last_of_run, output ready);
endinterface

interface ufd_csr_if;
   logic valid;
   logic ready;
   logic [ufd_pkg::CodeW-1:0] invalid_code;
   modport source(output valid, output invalid_code, input ready);
   modport sink(input valid, input invalid_code, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/ufd_decode.sv
// Combinational decode of one byte against the pending bytes: gives the
// batch of results and the bytes left pending. Depends on ufd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ufd_decode (
   input  wire logic [ufd_pkg::ByteW-1:0] pend_bytes [ufd_pkg::PendDepth],
   input  wire logic [1:0] pend_count,
   input  wire logic [ufd_pkg::ByteW-1:0] data_byte,
   input  wire logic end_of_string,
   input  wire logic [ufd_pkg::CodeW-1:0] invalid_code,
   output ufd_pkg::batch_type batch,
   output logic [ufd_pkg::ByteW-1:0] next_bytes [ufd_pkg::PendDepth],
   output logic [1:0] next_count
);

   always_comb begin
      logic [ufd_pkg::ByteW-1:0] seq_buf [4];
      logic [ufd_pkg::ByteW-1:0] lead, b1, b2, b3;
      logic [2:0] n, pos, k, len, avail, idx, rem;
      logic stop, bad;
      logic [ufd_pkg::CodeW-1:0] cp;

      lead = '0;
      b1 = '0;
      b2 = '0;
      b3 = '0;
      len = '0;
      avail = '0;
      idx = '0;
      rem = '0;
      bad = 1'b0;
      cp = '0;
      seq_buf[0] = pend_bytes[0];
      seq_buf[1] = pend_bytes[1];
      seq_buf[2] = pend_bytes[2];
      seq_buf[3] = '0;
      seq_buf[pend_count] = data_byte;
      n = {1'b0, pend_count} + 3'd1;
      pos = '0;
      k = '0;
      stop = 1'b0;
      batch = '0;

      // Each step takes the byte at pos as a lead; at most four leads fit.
      for (int step = 0; step < ufd_pkg::MaxResults; step++) begin
         if (!stop && (pos < n)) begin
            lead = seq_buf[pos[1:0]];
            len = ufd_pkg::seq_len(lead);
            avail = n - pos;
            bad = (len == ufd_pkg::LenNone);
            for (int f = 1; f < 4; f++) begin
               idx = pos + 3'(f);
               if ((3'(f) < len) && (3'(f) < avail) &&
                   !ufd_pkg::is_cont(seq_buf[idx[1:0]])) begin
                  bad = 1'b1;
               end
            end
            if (!bad && (len > avail)) begin
               if (end_of_string) begin
                  bad = 1'b1;
               end else begin
                  stop = 1'b1;
               end
            end
            idx = pos + 3'd1;
            b1 = seq_buf[idx[1:0]];
            idx = pos + 3'd2;
            b2 = seq_buf[idx[1:0]];
            idx = pos + 3'd3;
            b3 = seq_buf[idx[1:0]];
            case (len)
               ufd_pkg::Len1: cp = {13'd0, lead};
               ufd_pkg::Len2: cp = {10'd0, lead[4:0], b1[5:0]};
               ufd_pkg::Len3: cp = {5'd0, lead[3:0], b1[5:0], b2[5:0]};
               default:       cp = {lead[2:0], b1[5:0], b2[5:0], b3[5:0]};
            endcase
            if (!stop) begin
               batch.entry[k[1:0]].code_point = bad ? invalid_code : cp;
               batch.entry[k[1:0]].malformed = bad;
               batch.entry[k[1:0]].last_of_run = 1'b0;
               k = k + 3'd1;
               pos = pos + (bad ? 3'd1 : len);
            end
         end
      end

      if (k != 3'd0) begin
         idx = k - 3'd1;
         batch.entry[idx[1:0]].last_of_run = 1'b1;
      end
      batch.count = k;

      rem = n - pos;
      next_count = rem[1:0];
      for (int j = 0; j < ufd_pkg::PendDepth; j++) begin
         idx = pos + 3'(j);
         next_bytes[j] = (idx < 3'd4) ? seq_buf[idx[1:0]] : '0;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/ufd_result_queue.sv
// Result register that holds one item's batch of up to four results and
// hands them out one per cycle while out_ready is high. Depends on ufd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ufd_result_queue (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic load,
   input  wire ufd_pkg::batch_type batch,
   output logic can_load,
   output logic out_valid,
   input  wire logic out_ready,
   output ufd_pkg::result_type out_result,
   output logic [2:0] level
);

   ufd_pkg::result_type entry_ff [ufd_pkg::MaxResults];
   ufd_pkg::result_type entry_in [ufd_pkg::MaxResults];
   logic [2:0] count_ff, count_in;
   logic pop;

   assign pop = (count_ff != 3'd0) && out_ready;
   // A new batch may enter when none is held or the last held result leaves this cycle.
   assign can_load = (count_ff == 3'd0) || ((count_ff == 3'd1) && out_ready);
   assign out_valid = (count_ff != 3'd0);
   assign out_result = entry_ff[0];
   assign level = count_ff;

   always_comb begin
      entry_in = entry_ff;
      count_in = count_ff;
      if (load) begin
         for (int i = 0; i < ufd_pkg::MaxResults; i++) begin
            entry_in[i] = batch.entry[i];
         end
         count_in = batch.count;
      end else if (pop) begin
         for (int i = 0; i < ufd_pkg::MaxResults - 1; i++) begin
            entry_in[i] = entry_ff[i+1];
         end
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
`default_nettype wire

// File: hw/rtl/utf8_stream_decoder.sv
// UTF-8 stream decoder top level: input register, pending byte state,
// configuration register and assertions. Depends on ufd_pkg, the channel
// interfaces, ufd_decode, ufd_result_queue and the defines header.
//
// Usage: bytes enter on req_bus (data_byte, end_of_string) under valid/ready
// and code points leave on rsp_bus (code_point, malformed, last_of_run).
// csr_bus writes invalid_code, the value given for a malformed lead; it is
// always ready; it must be written only while the block is idle, which the block itself does not enforce.
// An accepted byte is held in the input register, then decoded into the
// result register, from which its first result is valid.
// Throughput: one byte per cycle while each byte gives at most one result and rsp_bus.ready is high.
// A byte that ends or breaks a sequence can give up to four results; the
// result register hands them out one per cycle while rsp_bus.ready is high,
// so such a byte holds the input until its last result leaves. Bytes that
// only extend a pending sequence give no result.
// Reset: clears the pending byte count, empties both registers and sets
// invalid_code to 65533. No clearing pass is needed.
// Stall: when rsp_bus.ready is low, the result register holds; req_bus.ready
// drops at once if the input register is full, else after one more item.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_stream_decoder_defines.svh"
module utf8_stream_decoder (
   input wire logic clock,
   input wire logic reset,
   ufd_req_if.sink req_bus,
   ufd_rsp_if.source rsp_bus,
   ufd_csr_if.sink csr_bus
);

   logic s1_valid_ff, s1_valid_in;
   logic [ufd_pkg::ByteW-1:0] s1_byte_ff;
   logic s1_eos_ff;
   logic [ufd_pkg::ByteW-1:0] pend_bytes_ff [ufd_pkg::PendDepth];
   logic [1:0] pend_count_ff;
   logic [ufd_pkg::CodeW-1:0] invalid_code_ff;

   ufd_pkg::batch_type dec_batch;
   logic [ufd_pkg::ByteW-1:0] dec_next_bytes [ufd_pkg::PendDepth];
   logic [1:0] dec_next_count;
   ufd_pkg::result_type out_result;
   logic q_can_load, q_out_valid;
   logic [2:0] q_level;
   logic req_accept, s1_move;

   assign s1_move = s1_valid_ff && q_can_load;
   assign req_bus.ready = !s1_valid_ff || q_can_load;
   assign req_accept = req_bus.valid && req_bus.ready;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_move);
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         pend_count_ff <= '0;
         invalid_code_ff <= ufd_pkg::InvalidCodeReset;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (s1_move) begin
            pend_count_ff <= dec_next_count;
         end
         if (csr_bus.valid) begin
            invalid_code_ff <= csr_bus.invalid_code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff <= req_bus.data_byte;
         s1_eos_ff <= req_bus.end_of_string;
      end
      if (s1_move) begin
         pend_bytes_ff <= dec_next_bytes;
      end
   end

   ufd_decode u_decode (
      .pend_bytes    (pend_bytes_ff),
      .pend_count    (pend_count_ff),
      .data_byte     (s1_byte_ff),
      .end_of_string (s1_eos_ff),
      .invalid_code  (invalid_code_ff),
      .batch         (dec_batch),
      .next_bytes    (dec_next_bytes),
      .next_count    (dec_next_count)
   );

   ufd_result_queue u_result_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (s1_move),
      .batch      (dec_batch),
      .can_load   (q_can_load),
      .out_valid  (q_out_valid),
      .out_ready  (rsp_bus.ready),
      .out_result (out_result),
      .level      (q_level)
   );

   assign rsp_bus.valid = q_out_valid;
   assign rsp_bus.code_point = out_result.code_point;
   assign rsp_bus.malformed = out_result.malformed;
   assign rsp_bus.last_of_run = out_result.last_of_run;

   // An end-of-string byte leaves nothing pending once it is decoded.
   `UFD_ASSERT_NEXT(a_eos_flushes, clock, reset, s1_move && s1_eos_ff, pend_count_ff == 2'd0)
   // Only the final result held for a byte carries last_of_run.
   `UFD_ASSERT_IMPLY(a_last_on_final, clock, reset, q_out_valid && (q_level == 3'd1),
                     out_result.last_of_run)
   `UFD_ASSERT_IMPLY(a_no_early_last, clock, reset, q_out_valid && (q_level > 3'd1),
                     !out_result.last_of_run)
   // A malformed result carries the configured substitute value.
   `UFD_ASSERT_IMPLY(a_malformed_code, clock, reset, q_out_valid && out_result.malformed,
                     out_result.code_point == invalid_code_ff)

endmodule
`default_nettype wire

// File: tb/tb_utf8_stream_decoder.sv
// Self-checking testbench for utf8_stream_decoder: drives byte items and
// invalid_code writes, predicts the code points and checks every result.
// Depends on ufd_pkg, the channel interfaces and the decoder RTL.
`timescale 1ns / 1ps
module tb_utf8_stream_decoder;

   localparam int CodeW = ufd_pkg::CodeW;
   localparam int ByteW = ufd_pkg::ByteW;
   localparam int CycleLimit = 500000;
   localparam int DrainCycles = 8;

   logic clock;
   logic reset;

   ufd_req_if req_bus();
   ufd_rsp_if rsp_bus();
   ufd_csr_if csr_bus();

   utf8_stream_decoder i_dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   // Decoder image kept by the testbench.
   logic [CodeW-1:0] cur_invalid_code;
   logic [ByteW-1:0] held_bytes[ufd_pkg::PendDepth];
   int held_count;
   ufd_pkg::result_type expected_code_points[$];

   int error_count;
   int cycle_count;
   bit pace_on;

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("tb_utf8_stream_decoder: errors");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Mostly short gaps, a few long ones, none while pacing is off.
   function automatic int gap_len();
      int r;
      if (!pace_on) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic int lead_length(input logic [ByteW-1:0] lead);
      if (lead < 8'h80) begin
         return 1;
      end else if (lead < 8'hC0) begin
         return 0;
      end else if (lead <= 8'hDF) begin
         return 2;
      end else if (lead <= 8'hEF) begin
         return 3;
      end
      return 4;
   endfunction

   // Appends one byte to the held bytes and queues every code point that it
   // completes. A bad lead costs one byte; the rest are retried as leads.
   task automatic decode_byte(input logic [ByteW-1:0] b, input logic eos);
      logic [ByteW-1:0] window[4];
      ufd_pkg::result_type res[ufd_pkg::MaxResults];
      logic [ByteW-1:0] lead;
      logic bad;
      int n, pos, len, avail, k, i;
      n = held_count;
      for (i = 0; i < n; i++) begin
         window[i] = held_bytes[i];
      end
      window[n] = b;
      n++;
      pos = 0;
      k = 0;
      while (pos < n) begin
         lead = window[pos];
         len = lead_length(lead);
         avail = n - pos;
         bad = (len == 0);
         for (i = 1; !bad && i < len && i < avail; i++) begin
            if (window[pos + i][7:6] != 2'b10) begin
               bad = 1'b1;
            end
         end
         if (!bad && len > avail) begin
            if (!eos) begin
               break;
            end
            bad = 1'b1;
         end
         res[k].last_of_run = 1'b0;
         if (bad) begin
            res[k].code_point = cur_invalid_code;
            res[k].malformed = 1'b1;
            pos += 1;
         end else begin
            res[k].malformed = 1'b0;
            case (len)
               1: begin
                  res[k].code_point = CodeW'(lead);
               end
               2: begin
                  res[k].code_point = CodeW'({lead[4:0], window[pos + 1][5:0]});
               end
               3: begin
                  res[k].code_point = CodeW'({lead[3:0], window[pos + 1][5:0],
                                              window[pos + 2][5:0]});
               end
               default: begin
                  res[k].code_point = {lead[2:0], window[pos + 1][5:0],
                                       window[pos + 2][5:0], window[pos + 3][5:0]};
               end
            endcase
            pos += len;
         end
         k++;
      end
      if (k > 0) begin
         res[k - 1].last_of_run = 1'b1;
      end
      for (i = 0; i < k; i++) begin
         expected_code_points.push_back(res[i]);
      end
      held_count = n - pos;
      for (i = 0; i < held_count; i++) begin
         held_bytes[i] = window[pos + i];
      end
   endtask

   task automatic send_item(input logic [ByteW-1:0] b, input logic eos);
      int g;
      g = gap_len();
      if (g > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (g - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.end_of_string <= eos;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      decode_byte(b, eos);
   endtask

   // Sends n bytes taken from the top of the low n bytes of seq.
   task automatic send_seq(input logic [31:0] seq, input int n, input logic eos_last);
      int i;
      for (i = 0; i < n; i++) begin
         send_item(seq[8 * (n - 1 - i) +: 8], eos_last && (i == n - 1));
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_code_points.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic set_invalid_code(input logic [CodeW-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.invalid_code <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      cur_invalid_code = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      ufd_pkg::result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_code_points.size() == 0) begin
            report_mismatch($sformatf("unexpected result cp=%06h mal=%0b last=%0b",
               rsp_bus.code_point, rsp_bus.malformed, rsp_bus.last_of_run));
         end else begin
            want = expected_code_points.pop_front();
            if (rsp_bus.code_point !== want.code_point) begin
               report_mismatch($sformatf("code_point %06h, expected %06h",
                  rsp_bus.code_point, want.code_point));
            end
            if (rsp_bus.malformed !== want.malformed) begin
               report_mismatch($sformatf("malformed %0b, expected %0b",
                  rsp_bus.malformed, want.malformed));
            end
            if (rsp_bus.last_of_run !== want.last_of_run) begin
               report_mismatch($sformatf("last_of_run %0b, expected %0b",
                  rsp_bus.last_of_run, want.last_of_run));
            end
         end
      end
   end

   // Result side back-pressure.
   initial begin
      int g;
      forever begin
         repeat ($urandom_range(1, 12)) @(negedge clock);
         g = gap_len();
         if (g > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (g) @(negedge clock);
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic test_ascii_bytes();
      send_seq(32'h0000_007F, 1, 1'b0);
      send_seq(32'h0000_0000, 1, 1'b1);
   endtask

   // Shortest and longest two- and three-byte forms, two four-byte forms,
   // overlong forms and leads above F7 included.
   task automatic test_multibyte_forms();
      send_seq(32'h0000_C080, 2, 1'b0);
      send_seq(32'h0000_DFBF, 2, 1'b1);
      send_seq(32'h00E0_8080, 3, 1'b0);
      send_seq(32'h00EF_BFBF, 3, 1'b0);
      send_seq(32'hF48F_BFBF, 4, 1'b0);
      send_seq(32'hFFBF_BFBF, 4, 1'b1);
   endtask

   task automatic test_malformed_leads();
      // Stray continuation byte, then a follower that breaks early.
      send_seq(32'h0000_0080, 1, 1'b0);
      send_seq(32'h0000_C341, 2, 1'b0);
      // The last byte breaks a four-byte lead: all held bytes come out in one batch.
      send_seq(32'hF09F_9841, 4, 1'b0);
      // Truncated by the end of the string.
      send_seq(32'h0000_E282, 2, 1'b1);
   endtask

   task automatic test_invalid_code_setting();
      set_invalid_code({CodeW{1'b1}});
      send_seq(32'h0000_BFC3, 2, 1'b1);
      set_invalid_code('0);
      send_seq(32'h00F0_9F41, 3, 1'b0);
   endtask

   // One well-formed sequence, a broken one, or a noise byte.
   task automatic send_random_unit(inout int sent);
      logic [31:0] seq;
      int r, len, i, cut;
      logic [ByteW-1:0] lead;
      r = $urandom_range(0, 99);
      if (r >= 85) begin
         send_item(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
         sent += 1;
         return;
      end
      len = (r >= 70) ? $urandom_range(2, 4) : $urandom_range(1, 4);
      case (len)
         1: lead = 8'($urandom_range(8'h00, 8'h7F));
         2: lead = 8'($urandom_range(8'hC0, 8'hDF));
         3: lead = 8'($urandom_range(8'hE0, 8'hEF));
         default: lead = 8'($urandom_range(8'hF0, 8'hFF));
      endcase
      seq = '0;
      seq[7:0] = lead;
      for (i = 1; i < len; i++) begin
         seq = {seq[23:0], 2'b10, 6'($urandom_range(0, 63))};
      end
      if (r >= 70) begin
         if ($urandom_range(0, 1) == 0) begin
            // Truncate, mostly closed by the end of the string.
            cut = $urandom_range(1, len - 1);
            seq = seq >> (8 * (len - cut));
            len = cut;
            send_seq(seq, len, $urandom_range(0, 3) != 0);
         end else begin
            // A follower that is no continuation byte.
            i = $urandom_range(0, len - 2);
            seq[8 * i +: 8] = {2'($urandom_range(0, 2) == 2 ? 3 : $urandom_range(0, 1)),
                               6'($urandom_range(0, 63))};
            send_seq(seq, len, $urandom_range(0, 7) == 0);
         end
      end else begin
         send_seq(seq, len, $urandom_range(0, 7) == 0);
      end
      sent += len;
   endtask

   task automatic test_random_traffic();
      int phase, sent;
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_invalid_code(ufd_pkg::InvalidCodeReset);
            3: set_invalid_code({CodeW{1'b1}});
            default: set_invalid_code(CodeW'($urandom_range(0, 2097151)));
         endcase
         pace_on = (phase != 2);
         sent = 0;
         while (sent < 87) begin
            send_random_unit(sent);
         end
      end
      pace_on = 1'b1;
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.data_byte = '0;
      req_bus.end_of_string = 1'b0;
      rsp_bus.ready = 1'b1;
      csr_bus.valid = 1'b0;
      csr_bus.invalid_code = '0;
      cur_invalid_code = ufd_pkg::InvalidCodeReset;
      held_count = 0;
      error_count = 0;
      cycle_count = 0;
      pace_on = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_ascii_bytes();
      test_multibyte_forms();
      test_malformed_leads();
      test_invalid_code_setting();
      test_random_traffic();

      wait_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_utf8_stream_decoder: clean");
      end else begin
         $display("tb_utf8_stream_decoder: errors");
      end
      $finish;
   end
endmodule

// File: utf8_stream_decoder.f
+incdir+hw/rtl
hw/rtl/ufd_pkg.sv
hw/rtl/ufd_channels_if.sv
hw/rtl/ufd_decode.sv
hw/rtl/ufd_result_queue.sv
hw/rtl/utf8_stream_decoder.sv
tb/tb_utf8_stream_decoder.sv
